FILE: design/esrf_pkg.sv
// esrf_pkg: shared types and constants for the escape-stuffed record framer
// no dependencies; imported by every module of the framer
`default_nettype none

package esrf_pkg;

	localparam int unsigned MAX_BYTES = 8;
	localparam int unsigned SLOT_W    = $clog2(MAX_BYTES);
	localparam int unsigned COUNT_W   = $clog2(MAX_BYTES + 1);

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_ESCAPE = 2'd0,
		REG_START  = 2'd1,
		REG_END    = 2'd2
	} esrf_reg_t;

	localparam logic [7:0] ESCAPE_RST = 8'd27;
	localparam logic [7:0] START_RST  = 8'd1;
	localparam logic [7:0] END_RST    = 8'd10;

	typedef struct packed {
		logic [7:0] escape_code;
		logic [7:0] start_code;
		logic [7:0] end_code;
	} esrf_cfg_t;

	// one item expanded into its framed output bytes
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] slots;
		logic [COUNT_W-1:0]        count;
		logic                      last;
	} esrf_frame_t;

endpackage

`default_nettype wire

FILE: design/esrf_cfg.sv
// esrf_cfg: code byte registers written through the configuration channel
// depends on esrf_pkg
`default_nettype none

module esrf_cfg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire logic [1:0]        wr_index,
	input  wire logic [7:0]        wr_data,
	output esrf_pkg::esrf_cfg_t    cfg
);
	import esrf_pkg::*;

	esrf_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.escape_code <= ESCAPE_RST;
			cfg_q.start_code  <= START_RST;
			cfg_q.end_code    <= END_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_ESCAPE: cfg_q.escape_code <= wr_data;
				REG_START:  cfg_q.start_code  <= wr_data;
				REG_END:    cfg_q.end_code    <= wr_data;
				default:    ; // index beyond the register list is dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

FILE: design/esrf_expand.sv
// esrf_expand: turns one input word into its list of framed, stuffed bytes
// depends on esrf_pkg
`default_nettype none

module esrf_expand (
	input  wire esrf_pkg::esrf_cfg_t cfg,
	input  wire logic                action,
	input  wire logic [7:0]          tag,
	input  wire logic [7:0]          data_byte,
	input  wire logic                has_data,
	input  wire logic                first_of_run,
	input  wire logic                last_of_run,
	output esrf_pkg::esrf_frame_t    frame
);
	import esrf_pkg::*;

	logic               hdr_en;
	logic               trl_en;
	logic               tag_esc;
	logic               dat_esc;
	logic [COUNT_W-1:0] hdr_len;
	logic [COUNT_W-1:0] dat_len;
	logic [COUNT_W-1:0] trl_len;
	logic [COUNT_W-1:0] dat_end;

	always_comb begin
		hdr_en  = !action && first_of_run;
		trl_en  = !action && last_of_run;
		tag_esc = (tag == cfg.escape_code);
		dat_esc = (data_byte == cfg.escape_code);
		hdr_len = hdr_en ? (COUNT_W'(3) + COUNT_W'(tag_esc)) : '0;
		dat_len = has_data ? (COUNT_W'(1) + COUNT_W'(dat_esc)) : '0;
		trl_len = trl_en ? COUNT_W'(2) : '0;
		dat_end = hdr_len + dat_len;
	end

	// each slot picks its byte from the header, data or trailer segment
	always_comb begin
		logic [COUNT_W-1:0] pos;
		logic [COUNT_W-1:0] rel;
		frame.count = dat_end + trl_len;
		frame.last  = last_of_run;
		for (int i = 0; i < MAX_BYTES; i++) begin
			pos = COUNT_W'(i);
			rel = '0;
			if (pos < hdr_len) begin
				case (pos[1:0])
					2'd0:    frame.slots[i] = cfg.escape_code;
					2'd1:    frame.slots[i] = cfg.start_code;
					2'd2:    frame.slots[i] = tag;
					default: frame.slots[i] = cfg.escape_code;
				endcase
			end else if (pos < dat_end) begin
				rel = pos - hdr_len;
				frame.slots[i] = rel[0] ? cfg.escape_code : data_byte;
			end else begin
				rel = pos - dat_end;
				frame.slots[i] = rel[0] ? cfg.end_code : cfg.escape_code;
			end
		end
	end

endmodule

`default_nettype wire

FILE: design/escape_stuffed_record_framer_unit.sv
// Escape-stuffed record framer. Each accepted word is expanded
// combinationally into up to eight framed bytes (escape, start code and
// stuffed tag on the first word of a record; the stuffed data byte; escape
// and end code on the last word), then those bytes leave one per cycle
// through a registered output unless out_stall holds them. A word occupies
// the byte sequencer until its last byte is loaded; the next word is taken
// in the cycle its predecessor's last byte is loaded, so sustained
// throughput is one byte per cycle without receiver stalls. Words that give
// no bytes never enter the sequencer. Configuration writes are always ready.
// depends on esrf_pkg, esrf_cfg, esrf_expand
`default_nettype none

module escape_stuffed_record_framer_unit (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       action,
	input  wire logic [7:0] tag,
	input  wire logic [7:0] data_byte,
	input  wire logic       has_data,
	input  wire logic       first_of_run,
	input  wire logic       last_of_run,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_byte,
	output logic            end_of_output
);
	import esrf_pkg::*;

	esrf_cfg_t   cfg;
	esrf_frame_t frame;
	esrf_frame_t frame_s1;
	logic        valid_s1;
	logic [SLOT_W-1:0] idx_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        eoo_q;
	logic        out_load;
	logic        at_last;
	logic        done_s1;
	logic        in_take;

	assign cfg_ready = 1'b1;

	esrf_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	esrf_expand u_expand (
		.cfg          (cfg),
		.action       (action),
		.tag          (tag),
		.data_byte    (data_byte),
		.has_data     (has_data),
		.first_of_run (first_of_run),
		.last_of_run  (last_of_run),
		.frame        (frame)
	);

	always_comb begin
		out_load = valid_s1 && (!out_valid_q || !out_stall);
		at_last  = ({1'b0, idx_q} == (frame_s1.count - COUNT_W'(1)));
		done_s1  = out_load && at_last;
		in_stall = valid_s1 && !done_s1;
		in_take  = in_valid && !in_stall;
	end

	// expanded word register; words that give no bytes are simply dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= (frame.count != '0);
		end else if (done_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			frame_s1 <= frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (done_s1) begin
			idx_q <= '0;
		end else if (out_load) begin
			idx_q <= idx_q + SLOT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_byte_q <= frame_s1.slots[idx_q];
			eoo_q      <= at_last && frame_s1.last;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_byte      = out_byte_q;
	assign end_of_output = eoo_q;

	// a held word always has bytes left to send
	a_held_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (frame_s1.count != '0))
		else $error("held word has no bytes");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> ({1'b0, idx_q} < frame_s1.count))
		else $error("byte index past end of word");

	// a new word only lands when the held one is finishing
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && valid_s1) |-> done_s1)
		else $error("held word overwritten");

	a_sequencer_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> (idx_q == '0))
		else $error("byte index not cleared between words");

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// testbench for escape_stuffed_record_framer_unit: random and directed words against a predictor
// depends on esrf_pkg and the framer rtl; self-contained, no files read

module testbench;
	import esrf_pkg::*;

	localparam bit ACT_RECORD = 1'b0;
	localparam bit ACT_RAW    = 1'b1;
	localparam int MAX_GAP    = 17;
	localparam int DRAIN_WAIT = 20;
	localparam int IDLE_LIMIT = 2000;

	typedef struct {
		bit       action;
		bit [7:0] tag;
		bit [7:0] data_byte;
		bit       has_data;
		bit       first_of_run;
		bit       last_of_run;
	} framer_word_t;

	typedef struct {
		logic [7:0] octet;
		logic       eoo;
	} framed_octet_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = REG_ESCAPE;
	logic [7:0] cfg_data = 8'd0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic       action = 1'b0;
	logic [7:0] tag = 8'd0;
	logic [7:0] data_byte = 8'd0;
	logic       has_data = 1'b0;
	logic       first_of_run = 1'b0;
	logic       last_of_run = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic       end_of_output;

	// predictor copy of the code registers
	logic [7:0] escape_code = ESCAPE_RST;
	logic [7:0] start_code  = START_RST;
	logic [7:0] end_code    = END_RST;

	framer_word_t  pending_words[$];
	framed_octet_t expected_octets[$];
	logic [7:0]    frame_octets[$];
	framer_word_t  cur_word;

	int  mismatches = 0;
	int  idle_cycles = 0;
	int  send_gap = 0;
	int  recv_gap = 0;
	bit  send_quiet = 1'b0;
	bit  recv_quiet = 1'b0;

	escape_stuffed_record_framer_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.action        (action),
		.tag           (tag),
		.data_byte     (data_byte),
		.has_data      (has_data),
		.first_of_run  (first_of_run),
		.last_of_run   (last_of_run),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_byte      (out_byte),
		.end_of_output (end_of_output)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic void append_octet(logic [7:0] b);
		frame_octets.insert(frame_octets.size(), b);
	endfunction

	function automatic void put_stuffed(logic [7:0] b);
		append_octet(b);
		if (b == escape_code)
			append_octet(escape_code);
	endfunction

	// expand one accepted word into the framed octets it must produce
	function automatic void frame_word(framer_word_t w);
		framed_octet_t fo;
		frame_octets.delete();
		if (w.action == ACT_RAW) begin
			if (w.has_data)
				put_stuffed(w.data_byte);
		end else begin
			if (w.first_of_run) begin
				append_octet(escape_code);
				append_octet(start_code);
				put_stuffed(w.tag);
			end
			if (w.has_data)
				put_stuffed(w.data_byte);
			if (w.last_of_run) begin
				append_octet(escape_code);
				append_octet(end_code);
			end
		end
		for (int i = 0; i < frame_octets.size(); i++) begin
			fo.octet = frame_octets[i];
			fo.eoo   = w.last_of_run && (i == frame_octets.size() - 1);
			expected_octets.insert(expected_octets.size(), fo);
		end
	endfunction

	// word driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (in_valid && !in_stall) begin
				frame_word(cur_word);
				if ($urandom_range(0, 29) == 0)
					send_quiet = !send_quiet;
				send_gap = send_quiet ? 0 : $urandom_range(0, MAX_GAP);
			end
			if (!in_valid || !in_stall) begin
				if (send_gap != 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_words.size() != 0) begin
					cur_word = pending_words.pop_front();
					in_valid     <= 1'b1;
					action       <= cur_word.action;
					tag          <= cur_word.tag;
					data_byte    <= cur_word.data_byte;
					has_data     <= cur_word.has_data;
					first_of_run <= cur_word.first_of_run;
					last_of_run  <= cur_word.last_of_run;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output monitor, receiver stalls, register tracking and watchdog
	always @(posedge clk) begin
		framed_octet_t exp_o;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (esrf_reg_t'(cfg_index))
					REG_ESCAPE: escape_code = cfg_data;
					REG_START:  start_code  = cfg_data;
					REG_END:    end_code    = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_octets.size() == 0) begin
					$error("unexpected output byte %0d", out_byte);
					mismatches++;
				end else begin
					exp_o = expected_octets.pop_front();
					if (out_byte !== exp_o.octet) begin
						$error("out_byte: expected %0d, got %0d", exp_o.octet, out_byte);
						mismatches++;
					end
					if (end_of_output !== exp_o.eoo) begin
						$error("end_of_output: expected %0d, got %0d", exp_o.eoo,
							end_of_output);
						mismatches++;
					end
				end
				if ($urandom_range(0, 59) == 0)
					recv_quiet = !recv_quiet;
				recv_gap = recv_quiet ? 0 : $urandom_range(0, MAX_GAP);
			end
			if (recv_gap != 0) begin
				recv_gap--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("escape_stuffed_record_framer_unit test failed");
				$finish;
			end
		end
	end

	task automatic add_word(bit act, bit [7:0] tg, bit [7:0] d, bit hd, bit f, bit l,
		inout int produced);
		framer_word_t w;
		w = '{act, tg, d, hd, f, l};
		pending_words.insert(pending_words.size(), w);
		if (act == ACT_RAW ? hd : (f || hd || l))
			produced++;
	endtask

	function automatic bit [7:0] pick_octet();
		int r;
		r = $urandom_range(0, 7);
		case (r)
			0, 1: return escape_code;
			2: return 8'd0;
			3: return 8'hff;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic random_words(int n);
		int produced;
		int len;
		int r;
		bit act;
		produced = 0;
		while (produced < n) begin
			r = $urandom_range(0, 99);
			if (r < 85) begin
				// well-formed record or raw run with random content
				act = (r < 60) ? ACT_RECORD : ACT_RAW;
				len = $urandom_range(1, 5);
				for (int i = 0; i < len; i++)
					add_word(act, pick_octet(), pick_octet(), $urandom_range(0, 7) != 0,
						i == 0, i == len - 1, produced);
			end else begin
				add_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), produced);
			end
		end
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_words.size() != 0 || in_valid || expected_octets.size() != 0);
	endtask

	task automatic write_reg(esrf_reg_t idx, logic [7:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_codes(logic [7:0] esc, logic [7:0] st, logic [7:0] en);
		wait_drained();
		// zero-byte words may still be in flight
		repeat (DRAIN_WAIT) @(posedge clk);
		write_reg(REG_ESCAPE, esc);
		write_reg(REG_START, st);
		write_reg(REG_END, en);
		@(negedge clk);
	endtask

	initial begin
		int n;
		n = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed words at reset codes
		add_word(ACT_RECORD, 8'd27, 8'd27, 1'b1, 1'b1, 1'b1, n);  // longest frame
		add_word(ACT_RECORD, 8'd0, 8'd0, 1'b0, 1'b1, 1'b1, n);    // empty record
		add_word(ACT_RECORD, 8'hff, 8'd0, 1'b1, 1'b1, 1'b0, n);
		add_word(ACT_RECORD, 8'h55, 8'hff, 1'b1, 1'b0, 1'b0, n);  // tag ignored mid record
		add_word(ACT_RECORD, 8'd27, 8'd27, 1'b1, 1'b0, 1'b1, n);
		add_word(ACT_RECORD, 8'd1, 8'd0, 1'b0, 1'b0, 1'b1, n);    // trailer with no header
		add_word(ACT_RECORD, 8'd10, 8'd0, 1'b0, 1'b0, 1'b0, n);
		add_word(ACT_RECORD, 8'd99, 8'd5, 1'b1, 1'b0, 1'b0, n);
		add_word(ACT_RAW, 8'd0, 8'd27, 1'b1, 1'b1, 1'b0, n);
		add_word(ACT_RAW, 8'hff, 8'd0, 1'b1, 1'b1, 1'b0, n);      // raw ignores first and tag
		add_word(ACT_RAW, 8'd0, 8'd0, 1'b0, 1'b0, 1'b1, n);       // empty raw item: nothing out
		add_word(ACT_RAW, 8'd27, 8'hff, 1'b1, 1'b0, 1'b1, n);
		add_word(ACT_RECORD, 8'd27, 8'd0, 1'b0, 1'b1, 1'b1, n);
		random_words(70);

		set_codes(8'd0, 8'hff, 8'd0);
		random_words(70);
		set_codes(8'hff, 8'd0, 8'hff);
		random_words(70);

		// start and end codes equal to the escape code
		set_codes(8'h7e, 8'h7e, 8'h7e);
		add_word(ACT_RECORD, 8'h7e, 8'h7e, 1'b1, 1'b1, 1'b1, n);
		add_word(ACT_RECORD, 8'h00, 8'h7e, 1'b0, 1'b1, 1'b1, n);
		random_words(70);

		set_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)));
		random_words(70);

		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (expected_octets.size() != 0) begin
			$error("%0d expected bytes never arrived", expected_octets.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("escape_stuffed_record_framer_unit test passed");
		else
			$display("escape_stuffed_record_framer_unit test failed");
		$finish;
	end

endmodule

FILE: files.f
design/esrf_pkg.sv
design/esrf_cfg.sv
design/esrf_expand.sv
design/escape_stuffed_record_framer_unit.sv
sim/testbench.sv
